// ===== design/sem3_pkg.sv =====
package sem3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // Fixed field widths of the stream and configuration payloads.
  localparam int unsigned PixW      = 8;
  localparam int unsigned DimW      = 11;
  localparam int unsigned OutCoordW = 10;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 32;

  // Counter and dimension widths that follow the frame limits.
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned WDimW = $clog2(MaxWidth + 1);
  localparam int unsigned HDimW = $clog2(MaxHeight + 1);

  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 480;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageHeight = CfgIdxW'(1);

  typedef logic [PixW-1:0] pixel_t;
  typedef logic [ColW-1:0] col_t;

  // Line store access for one pixel: read for the incoming pixel, write for
  // the pixel leaving the window stage.
  typedef struct packed {
    logic   rd_en;
    col_t   rd_addr;
    logic   wr_en;
    col_t   wr_addr;
    pixel_t wr_pix;
  } ls_req_t;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v, int unsigned maxv);
    int unsigned d;
    d = int'(v);
    if (d == 0) begin
      return 1;
    end
    if (d > maxv) begin
      return maxv;
    end
    return d;
  endfunction

endpackage

// ===== design/sem3_line_store.sv =====
module sem3_line_store
  import sem3_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ls_req_t req,
  output pixel_t  prev_pix,
  output pixel_t  prev2_pix
);

  // Both line stores share one address, so they live in one word:
  // upper byte is the previous row, lower byte the row before it.
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] rd_word_r;
  logic [2*PixW-1:0] fwd_word_r;
  logic              fwd_sel_r;
  logic [2*PixW-1:0] rd_word;
  logic [2*PixW-1:0] wr_word;

  assign rd_word   = fwd_sel_r ? fwd_word_r : rd_word_r;
  assign wr_word   = {req.wr_pix, rd_word[2*PixW-1:PixW]};
  assign prev_pix  = rd_word[2*PixW-1:PixW];
  assign prev2_pix = rd_word[PixW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      line_mem[req.wr_addr] <= wr_word;
    end
    if (req.rd_en) begin
      rd_word_r <= line_mem[req.rd_addr];
    end
  end

  // A read in the same cycle as a write to the same column (one-pixel rows)
  // sees old memory data, so the written word is taken instead.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_word_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (req.rd_en) begin
      fwd_sel_r <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

endmodule

// ===== design/sem3_window.sv =====
module sem3_window
  import sem3_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift_en,
  input  pixel_t col_top,
  input  pixel_t col_mid,
  input  pixel_t col_bot,
  output pixel_t magnitude
);

  localparam int unsigned GradW = PixW + 4;

  pixel_t win_r   [3][3];
  pixel_t win_nxt [3][3];

  logic signed [GradW-1:0] gx;
  logic signed [GradW-1:0] gy;
  logic [GradW-2:0]        abs_gx;
  logic [GradW-2:0]        abs_gy;
  logic [GradW-1:0]        sum;
  logic [GradW-2:0]        half;

  function automatic logic signed [GradW-1:0] sx(pixel_t p);
    return $signed({{(GradW-PixW){1'b0}}, p});
  endfunction

  // Window after this pixel: columns move left, new column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_top;
    win_nxt[1][2] = col_mid;
    win_nxt[2][2] = col_bot;
  end

  always_comb begin
    gx = (sx(win_nxt[0][2]) - sx(win_nxt[0][0]))
       + GradW'(2) * (sx(win_nxt[1][2]) - sx(win_nxt[1][0]))
       + (sx(win_nxt[2][2]) - sx(win_nxt[2][0]));
    gy = (sx(win_nxt[2][0]) - sx(win_nxt[0][0]))
       + GradW'(2) * (sx(win_nxt[2][1]) - sx(win_nxt[0][1]))
       + (sx(win_nxt[2][2]) - sx(win_nxt[0][2]));
    abs_gx = gx[GradW-1] ? (GradW-1)'(-gx) : gx[GradW-2:0];
    abs_gy = gy[GradW-1] ? (GradW-1)'(-gy) : gy[GradW-2:0];
    sum    = {1'b0, abs_gx} + {1'b0, abs_gy};
    half   = sum[GradW-1:1];
    magnitude = (half > (GradW-1)'(255)) ? 8'hFF : half[PixW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== design/sobel_edge_magnitude_3x3_unit.sv =====
// Streaming 3x3 Sobel edge magnitude, one 8-bit pixel accepted per clock in raster
// order unless stalled. Each pixel waits in the window stage, where the line stores
// (one 1024 x 16 memory) are read and written and the magnitude is formed, and then
// sits in a result register that sends up to three results, one per cycle while
// out_tready is high. Most pixels cause at most one result and flow at one pixel
// per cycle unless the output stalls; the last pixel of a row below the first and
// every pixel but the first of the last row cause two or three, and the input waits
// while the extras go out. Results trail the input by one row and one column; the
// last row goes out as zeros as it arrives. A size write restarts at row 0, col 0.
module sobel_edge_magnitude_3x3_unit
  import sem3_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [7:0] pixel_value
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [9:0] out_row, [19:10] out_col,
                                          // [27:20] magnitude, [31:28] zero
  output logic                out_tlast,  // run_last
  output logic                out_tuser,  // frame_done
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DimW-1:0]     cfg_data
);

  logic [WDimW-1:0] width_r;
  logic [HDimW-1:0] height_r;
  col_t             col_r;
  logic [RowW-1:0]  row_r;
  col_t             col_cur;
  logic [RowW-1:0]  row_cur;
  col_t             col_nxt;
  logic [RowW-1:0]  row_nxt;

  logic             a_valid_r;
  pixel_t           a_pix_r;
  col_t             a_col_r;
  logic [RowW-1:0]  a_row_r;

  logic [2:0]       pend_r;
  col_t             s_col_r;
  logic [RowW-1:0]  s_row_r;
  pixel_t           s_mag_r;
  logic             s_done_r;

  logic             in_fire;
  logic             out_fire;
  logic             cfg_fire;
  logic             a_adv;
  logic             slot_free;
  logic [2:0]       pend_low;
  logic [2:0]       pend_rest;
  logic [2:0]       pend_nxt;
  logic             a_col_last;
  logic             a_row_last;
  logic             a_interior;
  pixel_t           win_mag;
  pixel_t           prev_pix;
  pixel_t           prev2_pix;
  ls_req_t          ls_req;
  col_t             o_col;
  logic [RowW-1:0]  o_row;
  pixel_t           o_mag;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // Result register: pend_r bit 0 is the window result, bit 1 the right border
  // of the row above, bit 2 the zero of the last row. Lowest set bit goes first.
  assign pend_low  = pend_r & (~pend_r + 3'd1);
  assign pend_rest = pend_r & ~pend_low;
  assign slot_free = (pend_r == 3'b000) || (out_fire && (pend_rest == 3'b000));
  assign a_adv     = a_valid_r && slot_free;
  assign in_tready = !a_valid_r || a_adv;

  // Counters always stay inside the frame, the guard only mirrors a frame restart.
  always_comb begin
    if ({1'b0, col_r} >= width_r || {1'b0, row_r} >= height_r) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      col_cur = col_r;
      row_cur = row_r;
    end
    if ({1'b0, col_cur} == width_r - WDimW'(1)) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_cur} == height_r - HDimW'(1)) ? '0 : row_cur + RowW'(1);
    end else begin
      col_nxt = col_cur + ColW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WDimW'(ResetWidth);
      height_r <= HDimW'(ResetHeight);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        RegImageWidth: begin
          width_r <= WDimW'(clamp_dim(cfg_data, MaxWidth));
          col_r   <= '0;
          row_r   <= '0;
        end
        RegImageHeight: begin
          height_r <= HDimW'(clamp_dim(cfg_data, MaxHeight));
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r <= in_tdata[PixW-1:0];
      a_col_r <= col_cur;
      a_row_r <= row_cur;
    end
  end

  assign ls_req = '{rd_en:   in_fire,
                    rd_addr: col_cur,
                    wr_en:   a_adv,
                    wr_addr: a_col_r,
                    wr_pix:  a_pix_r};

  sem3_line_store u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ls_req),
    .prev_pix  (prev_pix),
    .prev2_pix (prev2_pix)
  );

  sem3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (a_adv),
    .col_top   (prev2_pix),
    .col_mid   (prev_pix),
    .col_bot   (a_pix_r),
    .magnitude (win_mag)
  );

  assign a_col_last = ({1'b0, a_col_r} == width_r - WDimW'(1));
  assign a_row_last = ({1'b0, a_row_r} == height_r - HDimW'(1));
  assign a_interior = (a_row_r >= RowW'(2)) && (a_col_r >= ColW'(2));
  assign pend_nxt   = {a_row_last,
                       (a_row_r != '0) && a_col_last,
                       (a_row_r != '0) && (a_col_r != '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else if (a_adv) begin
      pend_r <= pend_nxt;
    end else if (out_fire) begin
      pend_r <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      s_col_r  <= a_col_r;
      s_row_r  <= a_row_r;
      s_mag_r  <= a_interior ? win_mag : '0;
      s_done_r <= a_col_last;
    end
  end

  // The window result sits one column left; the border results of the row
  // above use that row, the last-row zero uses the current row and column.
  assign o_row = pend_low[2] ? s_row_r : s_row_r - RowW'(1);
  assign o_col = pend_low[0] ? s_col_r - ColW'(1) : s_col_r;
  assign o_mag = pend_low[0] ? s_mag_r : '0;

  assign out_tvalid = (pend_r != 3'b000);
  assign out_tlast  = (pend_rest == 3'b000);
  assign out_tuser  = pend_low[2] && s_done_r;
  assign out_tdata  = {(OutDataW - 2*OutCoordW - PixW)'(0), o_mag,
                       OutCoordW'(o_col), OutCoordW'(o_row)};

  // The frame's final result is always the last one its pixel causes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end not marked as last result of its pixel");

  // Nonzero magnitudes only come from interior windows.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[27:20] != 8'd0) |->
      (out_tdata[9:0] != 10'd0) && (out_tdata[19:10] != 10'd0))
    else $error("nonzero magnitude on a border pixel");

  // The input only stalls while the window stage holds an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> a_valid_r && !slot_free)
    else $error("input stalled with a free window stage");

  // A pixel leaves the window stage only into an empty or emptying result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> !$past(a_adv) || ($past(pend_r) == 3'b000))
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !a_valid_r)
    else $error("pipeline not empty after reset");

endmodule
